// ----- hw/rtl/bta_pkg.sv -----
// Shared types and codes for the bakery ticket arbiter.
package bta_pkg;

  // Command codes carried in an input beat
  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_ID    = 2'd1;
  localparam logic [1:0] STATUS_SATURATED = 2'd2;

  // Width of the active count register
  localparam int unsigned CountW = 4;
  localparam logic [CountW-1:0] CountReset = 4'd8;

  // Input beat
  typedef struct packed {
    logic       cmd;
    logic [2:0] proc_id;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [15:0] ticket;
    logic        granted;
    logic        holder_valid;
    logic [2:0]  holder_id;
    logic [1:0]  status;
  } out_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAX,
    ST_WRITE,
    ST_MIN,
    ST_DONE
  } state_e;

endpackage

// ----- hw/rtl/bta_ticket_store.sv -----
// Ticket store: one write port, one registered read port, per-entry valid bits.
module bta_ticket_store #(
  parameter int unsigned Depth = 8,
  parameter int unsigned Width = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Depth-1:0] valid_q;
  logic [Width-1:0] raw_q;
  logic             ok_q;

  // Valid bits: cleared at reset, set on first write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ok_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      ok_q <= valid_q[rd_addr_i];
    end
  end

  // Array write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    raw_q <= mem[rd_addr_i];
  end

  // Never-written entries read as zero
  assign rd_data_o = ok_q ? raw_q : '0;

endmodule

// ----- hw/rtl/bakery_ticket_arbiter.sv -----
// Top level of the bakery ticket arbiter: sequencer and shared comparator.
//
//   channel | direction | handshake               | beat
//   --------+-----------+-------------------------+------------------------------
//   in      | in        | in_valid_i / in_ready_o | bta_pkg::in_t (cmd, proc_id)
//   out     | out       | out_valid_o/out_ready_i | bta_pkg::out_t (result)
//   cfg     | in        | cfg_valid_i/cfg_ready_o | active_count, 4 bits
//
// An acquire walks the store once with the one comparator for the largest ticket,
// writes the new ticket, and walks again for the holder; a release writes a zero
// ticket and walks once for the holder, and a bad id only walks for the holder.
// The single read port of the ticket store sets the pace.
// Reset clears all tickets at once through valid bits and sets active_count
// to 8. The result is held in registers until taken; no new beat is taken meanwhile.
module bakery_ticket_arbiter #(
  parameter int unsigned MAX_PROCS   = 8,
  parameter int unsigned TICKET_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bta_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bta_pkg::out_t                out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bta_pkg::CountW-1:0]   cfg_data_i
);

  localparam int unsigned IdxW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CntW = IdxW + 1;

  bta_pkg::state_e        state_q, state_d;
  logic [bta_pkg::CountW-1:0] active_q;
  logic                   cmd_q, cmd_d;
  logic [2:0]             id_q, id_d;
  logic [CntW-1:0]        n_q, n_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   pend_q, pend_d;
  logic [IdxW-1:0]        pidx_q, pidx_d;
  logic [TICKET_BITS-1:0] acc_q, acc_d;
  logic                   found_q, found_d;
  logic [IdxW-1:0]        who_q, who_d;
  logic [TICKET_BITS-1:0] mine_q, mine_d;
  logic [1:0]             status_q, status_d;

  logic                   issue;
  logic                   wr_en;
  logic [TICKET_BITS-1:0] rd_data;
  logic [TICKET_BITS-1:0] cmp_a, cmp_b;
  logic                   cmp_lt;
  logic                   bad_id;
  logic [CntW-1:0]        n_live;

  // Ticket storage
  bta_ticket_store #(
    .Depth (MAX_PROCS),
    .Width (TICKET_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (IdxW'(id_q)),
    .wr_data_i (mine_d),
    .rd_addr_i (cnt_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  // Configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= bta_pkg::CountReset;
    end else if (cfg_valid_i) begin
      active_q <= cfg_data_i;
    end
  end

  // Live process count, capped at the store depth
  assign n_live = (int'(active_q) > int'(MAX_PROCS)) ? CntW'(MAX_PROCS) : CntW'(active_q);
  assign bad_id = int'(in_data_i.proc_id) >= int'(n_live);

  // Shared comparator: max scan asks acc < rd, min scan asks rd < acc
  assign cmp_a  = (state_q == bta_pkg::ST_MAX) ? acc_q : rd_data;
  assign cmp_b  = (state_q == bta_pkg::ST_MAX) ? rd_data : acc_q;
  assign cmp_lt = cmp_a < cmp_b;

  assign issue = cnt_q < n_q;

  // Sequencer: next state and datapath control
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    id_d     = id_q;
    n_d      = n_q;
    cnt_d    = cnt_q;
    pend_d   = 1'b0;
    pidx_d   = pidx_q;
    acc_d    = acc_q;
    found_d  = found_q;
    who_d    = who_q;
    mine_d   = mine_q;
    status_d = status_q;
    wr_en    = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      bta_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d    = in_data_i.cmd;
          id_d     = in_data_i.proc_id;
          n_d      = n_live;
          cnt_d    = '0;
          acc_d    = '0;
          found_d  = 1'b0;
          who_d    = '0;
          mine_d   = '0;
          status_d = bad_id ? bta_pkg::STATUS_BAD_ID : bta_pkg::STATUS_OK;
          if (bad_id) begin
            state_d = bta_pkg::ST_MIN;
          end else if (in_data_i.cmd == bta_pkg::CMD_ACQUIRE) begin
            state_d = bta_pkg::ST_MAX;
          end else begin
            state_d = bta_pkg::ST_WRITE;
          end
        end
      end

      bta_pkg::ST_MAX: begin
        // issue one read a cycle, fold the previous read into the maximum
        if (pend_q && cmp_lt) begin
          acc_d = rd_data;
        end
        if (issue) begin
          pend_d = 1'b1;
          pidx_d = cnt_q[IdxW-1:0];
          cnt_d  = cnt_q + 1'b1;
        end else begin
          state_d = bta_pkg::ST_WRITE;
        end
      end

      bta_pkg::ST_WRITE: begin
        wr_en = 1'b1;
        if (cmd_q == bta_pkg::CMD_RELEASE) begin
          mine_d = '0;
        end else if (&acc_q) begin
          mine_d   = acc_q;
          status_d = bta_pkg::STATUS_SATURATED;
        end else begin
          mine_d = acc_q + 1'b1;
        end
        cnt_d   = '0;
        acc_d   = '0;
        found_d = 1'b0;
        who_d   = '0;
        state_d = bta_pkg::ST_MIN;
      end

      bta_pkg::ST_MIN: begin
        // smallest nonzero ticket; strict compare keeps the lower id on ties
        if (pend_q && (rd_data != '0) && (!found_q || cmp_lt)) begin
          acc_d   = rd_data;
          found_d = 1'b1;
          who_d   = pidx_q;
        end
        if (issue) begin
          pend_d = 1'b1;
          pidx_d = cnt_q[IdxW-1:0];
          cnt_d  = cnt_q + 1'b1;
        end else begin
          state_d = bta_pkg::ST_DONE;
        end
      end

      bta_pkg::ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = bta_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bta_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bta_pkg::ST_IDLE;
      cmd_q    <= bta_pkg::CMD_ACQUIRE;
      id_q     <= '0;
      n_q      <= '0;
      cnt_q    <= '0;
      pend_q   <= 1'b0;
      pidx_q   <= '0;
      acc_q    <= '0;
      found_q  <= 1'b0;
      who_q    <= '0;
      mine_q   <= '0;
      status_q <= bta_pkg::STATUS_OK;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      id_q     <= id_d;
      n_q      <= n_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      pidx_q   <= pidx_d;
      acc_q    <= acc_d;
      found_q  <= found_d;
      who_q    <= who_d;
      mine_q   <= mine_d;
      status_q <= status_d;
    end
  end

  // Result beat, straight from registers
  always_comb begin
    out_data_o.ticket       = 16'(mine_q);
    out_data_o.granted      = found_q && (status_q != bta_pkg::STATUS_BAD_ID) &&
                              (int'(who_q) == int'(id_q));
    out_data_o.holder_valid = found_q;
    out_data_o.holder_id    = 3'(who_q);
    out_data_o.status       = status_q;
  end

`ifndef ASSERT_OFF
  // A grant always comes with a valid holder
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.granted || out_data_o.holder_valid))
    else $error("granted without a valid holder");

  // An ignored id leaves no ticket and no grant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == bta_pkg::STATUS_BAD_ID)) |->
    ((out_data_o.ticket == 16'd0) && !out_data_o.granted))
    else $error("bad id produced a ticket or grant");

  // No result is offered in the cycle after a beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!out_valid_o && !in_ready_o))
    else $error("result or ready too early after accept");
`endif

endmodule

// ----- verif/bta_ticket_checker.sv -----
// Result checker for the bakery ticket arbiter: predicts every result beat and compares it.
module bta_ticket_checker #(
  parameter int unsigned NumProcs = 8,
  parameter int unsigned TicketW  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  bta_pkg::in_t                 in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  bta_pkg::out_t                out_data_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [bta_pkg::CountW-1:0]   cfg_data_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Local copy of the arbiter state
  logic [TicketW-1:0]         tickets [NumProcs];
  logic [bta_pkg::CountW-1:0] active_count;

  // Results predicted but not yet seen on the output channel
  bta_pkg::out_t grants_due [$];
  int unsigned   mismatches = 0;

  // Apply one request beat to the local store and work out its result
  function automatic bta_pkg::out_t arbitrate(input bta_pkg::in_t beat);
    bta_pkg::out_t      res;
    int unsigned        live;
    logic [TicketW-1:0] top;
    logic [TicketW-1:0] mine;
    logic [TicketW-1:0] lowest;
    logic [1:0]         status;
    logic               found;
    logic [2:0]         who;
    live   = (active_count > NumProcs) ? NumProcs : active_count;
    mine   = '0;
    top    = '0;
    status = bta_pkg::STATUS_OK;
    if (beat.proc_id >= live) begin
      status = bta_pkg::STATUS_BAD_ID;
    end else if (beat.cmd == bta_pkg::CMD_ACQUIRE) begin
      for (int i = 0; i < live; i++) begin
        if (tickets[i] > top) begin
          top = tickets[i];
        end
      end
      if (top == '1) begin
        mine   = '1;
        status = bta_pkg::STATUS_SATURATED;
      end else begin
        mine = top + 1'b1;
      end
      tickets[beat.proc_id] = mine;
    end else begin
      tickets[beat.proc_id] = '0;
    end

    // Holder: smallest nonzero active ticket, lowest id on a tie
    found  = 1'b0;
    who    = '0;
    lowest = '0;
    for (int i = 0; i < live; i++) begin
      if (tickets[i] != '0 && (!found || tickets[i] < lowest)) begin
        found  = 1'b1;
        lowest = tickets[i];
        who    = 3'(i);
      end
    end

    res.ticket       = mine[15:0];
    res.granted      = found && status != bta_pkg::STATUS_BAD_ID && who == beat.proc_id;
    res.holder_valid = found;
    res.holder_id    = who;
    res.status       = status;
    return res;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      if (mismatches < 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
      mismatches++;
    end
  endtask

  // Track config and request beats, compare each result beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    bta_pkg::out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumProcs; i++) begin
        tickets[i] = '0;
      end
      active_count = bta_pkg::CountReset;
      grants_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        active_count = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        grants_due.push_back(arbitrate(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (grants_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result beat with nothing outstanding", $time);
          end
          mismatches++;
        end else begin
          want = grants_due.pop_front();
          check_field("ticket", want.ticket, out_data_i.ticket);
          check_field("granted", want.granted, out_data_i.granted);
          check_field("holder_valid", want.holder_valid, out_data_i.holder_valid);
          check_field("holder_id", want.holder_id, out_data_i.holder_id);
          check_field("status", want.status, out_data_i.status);
        end
      end
      pending_o <= grants_due.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the bakery ticket arbiter: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumProcs = 8;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  bta_pkg::in_t               in_data   = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  bta_pkg::out_t              out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [bta_pkg::CountW-1:0] cfg_data  = '0;

  int unsigned fails;
  int unsigned pending;

  // Stall controls shared by the request and result sides; live count of the request side
  bit          idle_on   = 1'b1;
  bit          long_hold = 1'b0;
  int unsigned live_now  = NumProcs;

  // Active counts visited first in the random part, extremes among them
  logic [bta_pkg::CountW-1:0] phase_counts [8] =
    '{4'd8, 4'd1, 4'd15, 4'd2, 4'd0, 4'd4, 4'd9, 4'd3};

  bakery_ticket_arbiter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  bta_ticket_checker ticket_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Offer one request beat after a random gap (none when idle_on is clear); valid stays up if the gap is zero
  task automatic send_beat(input logic cmd, input logic [2:0] id);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data.cmd     <= cmd;
    in_data.proc_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drain all outstanding results, then write the active count
  task automatic write_count(input logic [bta_pkg::CountW-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    live_now = (value > NumProcs) ? NumProcs : value;
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    wait (rst_n);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        stall     = 400;
      end else begin
        stall = idle_on ? $urandom_range(0, 17) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned beats;
    int unsigned drain;
    logic [2:0]  id;
    logic        cmd;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: order of tickets, re-acquire while holding, empty holder
    send_beat(bta_pkg::CMD_ACQUIRE, 3'd0);
    send_beat(bta_pkg::CMD_ACQUIRE, 3'd7);
    send_beat(bta_pkg::CMD_ACQUIRE, 3'd3);
    send_beat(bta_pkg::CMD_ACQUIRE, 3'd0);
    send_beat(bta_pkg::CMD_RELEASE, 3'd7);
    send_beat(bta_pkg::CMD_RELEASE, 3'd6);
    send_beat(bta_pkg::CMD_ACQUIRE, 3'd5);
    send_beat(bta_pkg::CMD_RELEASE, 3'd3);
    send_beat(bta_pkg::CMD_RELEASE, 3'd0);
    send_beat(bta_pkg::CMD_RELEASE, 3'd5);

    // Tie: an inactive ticket comes back level with an active one
    send_beat(bta_pkg::CMD_ACQUIRE, 3'd5);
    write_count(4'd5);
    send_beat(bta_pkg::CMD_ACQUIRE, 3'd0);
    write_count(4'd15);
    send_beat(bta_pkg::CMD_RELEASE, 3'd0);
    send_beat(bta_pkg::CMD_RELEASE, 3'd5);

    // Ids out of range, then no active process at all
    write_count(4'd3);
    send_beat(bta_pkg::CMD_ACQUIRE, 3'd7);
    send_beat(bta_pkg::CMD_RELEASE, 3'd3);
    send_beat(bta_pkg::CMD_ACQUIRE, 3'd2);
    send_beat(bta_pkg::CMD_ACQUIRE, 3'd1);
    write_count(4'd0);
    send_beat(bta_pkg::CMD_ACQUIRE, 3'd0);
    send_beat(bta_pkg::CMD_RELEASE, 3'd7);
    write_count(4'd8);
    send_beat(bta_pkg::CMD_RELEASE, 3'd1);
    send_beat(bta_pkg::CMD_RELEASE, 3'd2);

    // One active process, then a second one joins
    write_count(4'd1);
    send_beat(bta_pkg::CMD_RELEASE, 3'd1);
    write_count(4'd2);
    send_beat(bta_pkg::CMD_ACQUIRE, 3'd1);
    send_beat(bta_pkg::CMD_RELEASE, 3'd0);
    send_beat(bta_pkg::CMD_RELEASE, 3'd1);

    // Random phases, each under its own active count
    for (int phase = 0; phase < 14; phase++) begin
      write_count((phase < 8) ? phase_counts[phase] : 4'($urandom_range(0, 15)));
      idle_on = (phase % 4 != 3);
      beats   = (live_now == 0) ? 10 : 100;
      for (int k = 0; k < beats; k++) begin
        if (phase == 5 && k == 50) begin
          long_hold = 1'b1;
        end
        cmd = ($urandom_range(0, 9) < 6) ? bta_pkg::CMD_ACQUIRE : bta_pkg::CMD_RELEASE;
        if (live_now > 0 && $urandom_range(0, 9) != 0) begin
          id = 3'($urandom_range(0, live_now - 1));
        end else begin
          id = 3'($urandom_range(0, 7));
        end
        send_beat(cmd, id);
      end
    end
    idle_on = 1'b1;

    // Let the last results drain
    in_valid <= 1'b0;
    @(posedge clk);
    for (drain = 0; drain < 5000 && pending != 0; drain++) @(posedge clk);
    repeat (60) @(posedge clk);

    if (fails == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- bakery_ticket_arbiter.f -----
hw/rtl/bta_pkg.sv
hw/rtl/bta_ticket_store.sv
hw/rtl/bakery_ticket_arbiter.sv
verif/bta_ticket_checker.sv
verif/tb.sv
